// File: hw/rtl/lav_pkg.sv
// Shared types, constants and register codes of the look-at view axes block.
package lav_pkg;

   // Width of one Q2.30 axis component and of one Q16.16 coordinate
   localparam int AXIS_W  = 32;
   localparam int COORD_W = 32;
   localparam logic signed [63:0] AXIS_ONE = 64'sd1073741824;

   // Normalizer pipeline: square root steps, divider steps, total depth
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

   // Reset values of the up vector
   localparam logic [31:0] UP_X_RESET = 32'd0;
   localparam logic [31:0] UP_Y_RESET = 32'd65536;
   localparam logic [31:0] UP_Z_RESET = 32'd0;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_UP_X = 2'd0,
      REG_UP_Y = 2'd1,
      REG_UP_Z = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
      logic signed [AXIS_W-1:0] right_z;
      logic signed [AXIS_W-1:0] upaxis_x;
      logic signed [AXIS_W-1:0] upaxis_y;
      logic signed [AXIS_W-1:0] upaxis_z;
      logic signed [AXIS_W-1:0] forward_x;
      logic signed [AXIS_W-1:0] forward_y;
      logic signed [AXIS_W-1:0] forward_z;
      logic                     degenerate;
   } rsp_type;

endpackage

// File: hw/rtl/lav_norm.sv
// Pipelined exact normalizer of a signed 3-vector to Q2.30 with a side channel.
module lav_norm import lav_pkg::*; #(
   parameter int VW = 33,
   parameter int SW = 96
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [2:0][VW-1:0]         in_vec,
   input  logic [SW-1:0]              in_side,
   output logic                       out_valid,
   output logic                       out_ok,
   output logic [2:0][AXIS_W-1:0]     out_vec,
   output logic [SW-1:0]              out_side
);

   localparam int CW      = SW + 5;
   localparam int ST_SQ0  = 4;
   localparam int ST_SQN  = ST_SQ0 + SQRT_STEPS;
   localparam int ST_DIV0 = ST_SQN + 1;
   localparam int ST_DIVN = ST_DIV0 + DIV_STEPS;
   localparam int ST_OUT  = ST_DIVN + 1;

   // control line: valid, nonzero flag, signs, side word
   logic [CW-1:0] ctl_ff [ST_OUT+1];
   logic [CW-1:0] ctl_in;

   logic [2:0][VW-1:0] mag0_ff, mag0_in, mag1_ff;
   logic [5:0]         p_ff, p_in;
   logic [2:0][29:0]   sm_ff [2:ST_SQN];
   logic [2:0][29:0]   sm_in;
   logic [2:0][59:0]   sqr_ff, sqr_in;
   logic [63:0]        sn_ff [ST_SQ0:ST_SQN];
   logic [63:0]        sr_ff [ST_SQ0:ST_SQN];
   logic [63:0]        sn_in [ST_SQ0+1:ST_SQN];
   logic [63:0]        sr_in [ST_SQ0+1:ST_SQN];
   logic [63:0]        sum_in;
   logic [2:0][60:0]   rem_ff [ST_DIV0:ST_DIVN];
   logic [2:0][30:0]   quo_ff [ST_DIV0:ST_DIVN];
   logic [30:0]        dvs_ff [ST_DIV0:ST_DIVN];
   logic [2:0][60:0]   rem_in [ST_DIV0:ST_DIVN];
   logic [2:0][30:0]   quo_in [ST_DIV0:ST_DIVN];
   logic [2:0][AXIS_W-1:0] out_vec_ff, out_vec_in;

   // take magnitudes and signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag0_in[i] = in_vec[i][VW-1] ? VW'(-in_vec[i]) : in_vec[i];
      end
      ctl_in = {in_valid, (in_vec != '0), in_vec[2][VW-1], in_vec[1][VW-1],
                in_vec[0][VW-1], in_side};
   end

   // find the top set bit of the largest magnitude
   always_comb begin
      logic [63:0] x_v;
      x_v  = 64'(mag0_ff[0] | mag0_ff[1] | mag0_ff[2]);
      p_in = '0;
      for (int k = 5; k >= 0; k--) begin
         if ((x_v >> (1 << k)) != 64'd0) begin
            p_in = p_in + 6'(1 << k);
            x_v  = x_v >> (1 << k);
         end
      end
   end

   // scale so the largest magnitude lies in [2^29, 2^30), then square
   always_comb begin
      logic [63:0] w_v;
      for (int i = 0; i < 3; i++) begin
         w_v = 64'(mag1_ff[i]);
         if (p_ff > 6'd29) w_v = w_v >> (p_ff - 6'd29);
         else              w_v = w_v << (6'd29 - p_ff);
         sm_in[i]  = w_v[29:0];
         sqr_in[i] = 60'(sm_ff[2][i]) * 60'(sm_ff[2][i]);
      end
      sum_in = 64'(sqr_ff[0]) + 64'(sqr_ff[1]) + 64'(sqr_ff[2]);
   end

   // one bit pair of the square root per stage
   always_comb begin
      logic [63:0] bit_v, t_v;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         bit_v = 64'd1 << (62 - 2 * k);
         t_v   = sr_ff[ST_SQ0+k] + bit_v;
         if (sn_ff[ST_SQ0+k] >= t_v) begin
            sn_in[ST_SQ0+k+1] = sn_ff[ST_SQ0+k] - t_v;
            sr_in[ST_SQ0+k+1] = (sr_ff[ST_SQ0+k] >> 1) + bit_v;
         end else begin
            sn_in[ST_SQ0+k+1] = sn_ff[ST_SQ0+k];
            sr_in[ST_SQ0+k+1] = sr_ff[ST_SQ0+k] >> 1;
         end
      end
   end

   // divider load with half-divisor rounding, then one quotient bit per stage
   always_comb begin
      logic [63:0] cmp_v;
      for (int i = 0; i < 3; i++) begin
         rem_in[ST_DIV0][i] = 61'({sm_ff[ST_SQN][i], 30'd0}) + 61'(sr_ff[ST_SQN] >> 1);
         quo_in[ST_DIV0][i] = '0;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         for (int i = 0; i < 3; i++) begin
            cmp_v = 64'(dvs_ff[ST_DIV0+j]) << (30 - j);
            rem_in[ST_DIV0+j+1][i] = rem_ff[ST_DIV0+j][i];
            quo_in[ST_DIV0+j+1][i] = quo_ff[ST_DIV0+j][i];
            if (64'(rem_ff[ST_DIV0+j][i]) >= cmp_v) begin
               rem_in[ST_DIV0+j+1][i] = rem_ff[ST_DIV0+j][i] - cmp_v[60:0];
               quo_in[ST_DIV0+j+1][i][30-j] = 1'b1;
            end
         end
      end
   end

   // put signs back, zero a null vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!ctl_ff[ST_DIVN][CW-2])       out_vec_in[i] = '0;
         else if (ctl_ff[ST_DIVN][SW+i])   out_vec_in[i] = -AXIS_W'(quo_ff[ST_DIVN][i]);
         else                              out_vec_in[i] = AXIS_W'(quo_ff[ST_DIVN][i]);
      end
   end

   // advance the control line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ST_OUT; s++) ctl_ff[s] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s <= ST_OUT; s++) ctl_ff[s] <= ctl_ff[s-1];
      end
   end

   // advance the data stages
   always_ff @(posedge clock) begin
      mag0_ff   <= mag0_in;
      mag1_ff   <= mag0_ff;
      p_ff      <= p_in;
      sm_ff[2]  <= sm_in;
      sqr_ff    <= sqr_in;
      for (int s = 3; s <= ST_SQN; s++) sm_ff[s] <= sm_ff[s-1];
      sn_ff[ST_SQ0] <= sum_in;
      sr_ff[ST_SQ0] <= '0;
      for (int s = ST_SQ0 + 1; s <= ST_SQN; s++) begin
         sn_ff[s] <= sn_in[s];
         sr_ff[s] <= sr_in[s];
      end
      dvs_ff[ST_DIV0] <= sr_ff[ST_SQN][30:0];
      for (int s = ST_DIV0; s <= ST_DIVN; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
      end
      for (int s = ST_DIV0 + 1; s <= ST_DIVN; s++) dvs_ff[s] <= dvs_ff[s-1];
      out_vec_ff <= out_vec_in;
   end

   assign out_valid = ctl_ff[ST_OUT][CW-1];
   assign out_ok    = ctl_ff[ST_OUT][CW-2];
   assign out_side  = ctl_ff[ST_OUT][SW-1:0];
   assign out_vec   = out_vec_ff;

endmodule

// File: hw/rtl/look_at_view_axes.sv
// Top level of the look-at view axes block: register port, cross products, output word.
//
// Takes one camera setup (target and eye, Q16.16) per cycle whenever start is high;
// busy never rises, as the whole datapath is a free-running pipeline. Each word comes
// out on rsp_payload with rsp_valid high for one cycle, after passing one difference
// stage, two normalizers of 70 stages each (32 square-root stages and 31 divider
// stages, one result bit per stage), and two stages each for the two cross
// products. The up vector is read from the register port as the word enters; write
// it only while no word is in flight.
module look_at_view_axes import lav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0][31:0]  up_ff;
   logic              d_valid_ff;
   logic [2:0][32:0]  d_ff, d_in;
   logic [2:0][31:0]  up_s_ff;

   logic                    n1_valid, n1_ok;
   logic [2:0][AXIS_W-1:0]  n1_vec;
   logic [95:0]             n1_side;
   logic [2:0][31:0]        n1_up;

   logic                    c1_valid_ff, c2_valid_ff;
   logic signed [63:0]      cp_ff [6];
   logic signed [63:0]      cp_in [6];
   logic [2:0][AXIS_W-1:0]  z_c1_ff, z_c2_ff;
   logic [2:0][63:0]        c_ff, c_in;

   logic                    n2_valid, n2_ok;
   logic [2:0][AXIS_W-1:0]  n2_vec;
   logic [95:0]             n2_side;
   logic [2:0][AXIS_W-1:0]  n2_z;

   logic                    y1_valid_ff, y1_ok_ff;
   logic signed [63:0]      yp_ff [6];
   logic signed [63:0]      yp_in [6];
   logic [2:0][AXIS_W-1:0]  x_y1_ff, z_y1_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // register write and read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= UP_X_RESET;
         up_ff[1] <= UP_Y_RESET;
         up_ff[2] <= UP_Z_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx_type'(paddr[3:2]))
            REG_UP_X: up_ff[0] <= pwdata;
            REG_UP_Y: up_ff[1] <= pwdata;
            REG_UP_Z: up_ff[2] <= pwdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx_type'(paddr[3:2]))
         REG_UP_X: prdata = up_ff[0];
         REG_UP_Y: prdata = up_ff[1];
         REG_UP_Z: prdata = up_ff[2];
         default:  prdata = '0;
      endcase
   end

   // form target minus eye
   always_comb begin
      d_in[0] = 33'($signed(req_payload.target_x)) - 33'($signed(req_payload.eye_x));
      d_in[1] = 33'($signed(req_payload.target_y)) - 33'($signed(req_payload.eye_y));
      d_in[2] = 33'($signed(req_payload.target_z)) - 33'($signed(req_payload.eye_z));
   end

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else       d_valid_ff <= start;
      d_ff    <= d_in;
      up_s_ff <= up_ff;
   end

   // forward axis
   lav_norm #(.VW(33), .SW(96)) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d_valid_ff),
      .in_vec   (d_ff),
      .in_side  (up_s_ff),
      .out_valid(n1_valid),
      .out_ok   (n1_ok),
      .out_vec  (n1_vec),
      .out_side (n1_side)
   );

   assign n1_up = n1_side;

   // up cross forward: products, then differences
   always_comb begin
      cp_in[0] = 64'($signed(n1_up[1])) * 64'($signed(n1_vec[2]));
      cp_in[1] = 64'($signed(n1_up[2])) * 64'($signed(n1_vec[1]));
      cp_in[2] = 64'($signed(n1_up[2])) * 64'($signed(n1_vec[0]));
      cp_in[3] = 64'($signed(n1_up[0])) * 64'($signed(n1_vec[2]));
      cp_in[4] = 64'($signed(n1_up[0])) * 64'($signed(n1_vec[1]));
      cp_in[5] = 64'($signed(n1_up[1])) * 64'($signed(n1_vec[0]));
      c_in[0]  = cp_ff[0] - cp_ff[1];
      c_in[1]  = cp_ff[2] - cp_ff[3];
      c_in[2]  = cp_ff[4] - cp_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= n1_valid;
         c2_valid_ff <= c1_valid_ff;
      end
      for (int i = 0; i < 6; i++) cp_ff[i] <= cp_in[i];
      z_c1_ff <= n1_ok ? n1_vec : '0;
      c_ff    <= c_in;
      z_c2_ff <= z_c1_ff;
   end

   // right axis; forward travels alongside
   lav_norm #(.VW(64), .SW(96)) u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c2_valid_ff),
      .in_vec   (c_ff),
      .in_side  (z_c2_ff),
      .out_valid(n2_valid),
      .out_ok   (n2_ok),
      .out_vec  (n2_vec),
      .out_side (n2_side)
   );

   assign n2_z = n2_side;

   // forward cross right: products
   always_comb begin
      yp_in[0] = 64'($signed(n2_z[1])) * 64'($signed(n2_vec[2]));
      yp_in[1] = 64'($signed(n2_z[2])) * 64'($signed(n2_vec[1]));
      yp_in[2] = 64'($signed(n2_z[2])) * 64'($signed(n2_vec[0]));
      yp_in[3] = 64'($signed(n2_z[0])) * 64'($signed(n2_vec[2]));
      yp_in[4] = 64'($signed(n2_z[0])) * 64'($signed(n2_vec[1]));
      yp_in[5] = 64'($signed(n2_z[1])) * 64'($signed(n2_vec[0]));
   end

   // round to Q2.30, clamp, zero everything on a degenerate setup
   always_comb begin
      logic signed [63:0] y_v [3];
      for (int i = 0; i < 3; i++) begin
         y_v[i] = (yp_ff[2*i] - yp_ff[2*i+1] + 64'sd536870912) >>> 30;
         if (y_v[i] > AXIS_ONE)  y_v[i] = AXIS_ONE;
         if (y_v[i] < -AXIS_ONE) y_v[i] = -AXIS_ONE;
         if (!y1_ok_ff)          y_v[i] = '0;
      end
      rsp_in.right_x    = x_y1_ff[0];
      rsp_in.right_y    = x_y1_ff[1];
      rsp_in.right_z    = x_y1_ff[2];
      rsp_in.upaxis_x   = y_v[0][AXIS_W-1:0];
      rsp_in.upaxis_y   = y_v[1][AXIS_W-1:0];
      rsp_in.upaxis_z   = y_v[2][AXIS_W-1:0];
      rsp_in.forward_x  = y1_ok_ff ? z_y1_ff[0] : '0;
      rsp_in.forward_y  = y1_ok_ff ? z_y1_ff[1] : '0;
      rsp_in.forward_z  = y1_ok_ff ? z_y1_ff[2] : '0;
      rsp_in.degenerate = !y1_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         y1_valid_ff  <= n2_valid;
         rsp_valid_ff <= y1_valid_ff;
      end
      for (int i = 0; i < 6; i++) yp_ff[i] <= yp_in[i];
      y1_ok_ff <= n2_ok;
      x_y1_ff  <= n2_vec;
      z_y1_ff  <= n2_z;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: test/look_at_view_axes_test.sv
// Self-checking testbench of the look-at view axes block: directed table, random camera setups.
`timescale 1ns / 100ps

module look_at_view_axes_test;
   import lav_pkg::*;

   localparam int  LATENCY     = 145;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic signed [31:0] Q_ONE  = 32'sd65536;
   localparam logic signed [31:0] C_MAX  = 32'sh7fffffff;
   localparam logic signed [31:0] C_MIN  = 32'sh80000000;
   localparam logic signed [31:0] A_ONE  = 32'sh40000000;
   localparam logic signed [31:0] A_MONE = -32'sh40000000;

   typedef struct {
      req_type cam;
      bit      typed_in;
      rsp_type typed_axes;
   } cam_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Up vector as the predictor sees it
   logic signed [31:0] up_vec [3];
   // Expected view axes, oldest first, and the typed-in words waiting for acceptance
   rsp_type     axes_q [$];
   cam_row_type issue_q [$];
   cam_row_type table_rows [$];

   int fail_count;
   int cycle_count;
   int words_sent;
   int words_checked;
   int degenerate_seen;

   look_at_view_axes u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Integer square root, floor
   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale to [2^29, 2^30), divide by the length; returns 0 on a zero vector
   function automatic bit unit_vec(input longint v [3], output longint o [3]);
      logic [63:0] mag [3];
      bit          neg [3];
      logic [63:0] m, sum, s, q;
      int          p;
      m = 0;
      sum = 0;
      p = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'd0 - 64'(v[i]) : 64'(v[i]);
         if (mag[i] > m) m = mag[i];
         o[i] = 0;
      end
      if (m == 0) return 1'b0;
      while (p < 63 && (m >> (p + 1)) != 0) p++;
      for (int i = 0; i < 3; i++) begin
         if (p > 29) mag[i] = mag[i] >> (p - 29);
         else if (p < 29) mag[i] = mag[i] << (29 - p);
         sum = sum + mag[i] * mag[i];
      end
      s = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << 30) + (s >> 1)) / s;
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   // Q4.60 to Q2.30, round half up, clamp to one
   function automatic longint to_axis(input longint p);
      logic [63:0] t;
      longint      r;
      t = 64'(p + (64'sd1 << 29) + (64'sd1 << 62)) >> 30;
      r = longint'(t) - (64'sd1 << 32);
      if (r > 64'sd1073741824) r = 64'sd1073741824;
      if (r < -64'sd1073741824) r = -64'sd1073741824;
      return r;
   endfunction

   // Work out the view axes of one camera setup
   function automatic rsp_type view_axes(input req_type cam);
      longint  d [3], u [3], z [3], c [3], x [3], y [3];
      bit      ok;
      rsp_type r;
      d[0] = longint'($signed(cam.target_x)) - longint'($signed(cam.eye_x));
      d[1] = longint'($signed(cam.target_y)) - longint'($signed(cam.eye_y));
      d[2] = longint'($signed(cam.target_z)) - longint'($signed(cam.eye_z));
      for (int i = 0; i < 3; i++) u[i] = longint'(up_vec[i]);
      ok = unit_vec(d, z);
      if (ok) begin
         c[0] = u[1] * z[2] - u[2] * z[1];
         c[1] = u[2] * z[0] - u[0] * z[2];
         c[2] = u[0] * z[1] - u[1] * z[0];
         ok = unit_vec(c, x);
      end
      if (ok) begin
         y[0] = to_axis(z[1] * x[2] - z[2] * x[1]);
         y[1] = to_axis(z[2] * x[0] - z[0] * x[2]);
         y[2] = to_axis(z[0] * x[1] - z[1] * x[0]);
      end else begin
         for (int i = 0; i < 3; i++) begin
            x[i] = 0;
            y[i] = 0;
            z[i] = 0;
         end
      end
      r.right_x   = x[0][31:0];
      r.right_y   = x[1][31:0];
      r.right_z   = x[2][31:0];
      r.upaxis_x  = y[0][31:0];
      r.upaxis_y  = y[1][31:0];
      r.upaxis_z  = y[2][31:0];
      r.forward_x = z[0][31:0];
      r.forward_y = z[1][31:0];
      r.forward_z = z[2][31:0];
      r.degenerate = !ok;
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH at cycle %0d word %0d: %s got %h expected %h",
               cycle_count, words_checked, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report(what, got, want);
   endtask

   // Drive one word and hold it until taken; start stays high for the caller
   task automatic send_cam(input cam_row_type row);
      start <= 1'b1;
      req_payload <= row.cam;
      issue_q.push_back(row);
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Setup, access, then a return to idle so writes never overlap
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every word is back, then let the pipeline drain
   task automatic drain();
      start <= 1'b0;
      while (axes_q.size() != 0 || issue_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_up(input logic [31:0] ux, input logic [31:0] uy, input logic [31:0] uz);
      drain();
      csr_write(REG_UP_X, ux);
      csr_write(REG_UP_Y, uy);
      csr_write(REG_UP_Z, uz);
   endtask

   function automatic cam_row_type cam_row(input logic [31:0] tx, ty, tz, ex, ey, ez);
      cam_row_type row;
      row.cam = '{tx, ty, tz, ex, ey, ez};
      row.typed_in = 1'b0;
      row.typed_axes = '0;
      return row;
   endfunction

   function automatic cam_row_type typed_row(input cam_row_type row, input rsp_type axes);
      row.typed_in = 1'b1;
      row.typed_axes = axes;
      return row;
   endfunction

   // Random camera: nearby eye and target most often, some wide spreads and special shapes
   function automatic cam_row_type random_cam();
      cam_row_type row;
      int          kind;
      logic [31:0] span;
      kind = $urandom_range(0, 99);
      row = cam_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (kind < 45) begin
         span = 32'hffffffff >> $urandom_range(0, 31);
         row.cam.eye_x = row.cam.target_x + ($urandom & span);
         row.cam.eye_y = row.cam.target_y - ($urandom & span);
         row.cam.eye_z = row.cam.target_z + ($urandom & span);
      end else if (kind < 52) begin
         row.cam.eye_x = row.cam.target_x;
         row.cam.eye_y = row.cam.target_y;
         row.cam.eye_z = row.cam.target_z;
      end else if (kind < 60) begin
         // look along the up vector
         row.cam.target_x = up_vec[0];
         row.cam.target_y = up_vec[1];
         row.cam.target_z = up_vec[2];
         row.cam.eye_x = 0;
         row.cam.eye_y = 0;
         row.cam.eye_z = 0;
      end else if (kind < 68) begin
         row.cam.eye_x = row.cam.target_x;
         row.cam.eye_z = row.cam.target_z + $urandom_range(1, 3);
      end
      return row;
   endfunction

   // Sender: bursts of random length, random gaps, some bursts back to back
   task automatic random_phase(input int n);
      int left, burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_cam(random_cam());
         left -= burst;
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 7));
      end
   endtask

   // Count cycles, stop at the limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Predict on acceptance; follow register writes
   always @(posedge clock) begin
      cam_row_type row;
      if (!reset && psel && penable && pwrite && pready)
         up_vec[paddr[3:2]] = pwdata;
      if (!reset && start && !busy) begin
         if (issue_q.size() == 0) begin
            report("accepted word not issued", 0, 0);
         end else begin
            row = issue_q.pop_front();
            axes_q.push_back(row.typed_in ? row.typed_axes : view_axes(row.cam));
         end
      end
   end

   // Compare each word with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (axes_q.size() == 0) begin
            report("word with nothing expected", rsp_payload.right_x, 0);
         end else begin
            want = axes_q.pop_front();
            check_field("right_x", rsp_payload.right_x, want.right_x);
            check_field("right_y", rsp_payload.right_y, want.right_y);
            check_field("right_z", rsp_payload.right_z, want.right_z);
            check_field("upaxis_x", rsp_payload.upaxis_x, want.upaxis_x);
            check_field("upaxis_y", rsp_payload.upaxis_y, want.upaxis_y);
            check_field("upaxis_z", rsp_payload.upaxis_z, want.upaxis_z);
            check_field("forward_x", rsp_payload.forward_x, want.forward_x);
            check_field("forward_y", rsp_payload.forward_y, want.forward_y);
            check_field("forward_z", rsp_payload.forward_z, want.forward_z);
            check_field("degenerate", 32'(rsp_payload.degenerate), 32'(want.degenerate));
            if (want.degenerate) degenerate_seen++;
         end
         words_checked++;
      end
   end

   initial begin
      rsp_type flat_z, back_z, none;
      int      limit;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      cycle_count = 0;
      words_sent = 0;
      words_checked = 0;
      degenerate_seen = 0;
      up_vec[0] = UP_X_RESET;
      up_vec[1] = UP_Y_RESET;
      up_vec[2] = UP_Z_RESET;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Typed axes for the reset up vector
      none = '0;
      none.degenerate = 1'b1;
      flat_z = '{A_ONE, 0, 0, 0, A_ONE, 0, 0, 0, A_ONE, 1'b0};
      back_z = '{A_MONE, 0, 0, 0, A_ONE, 0, 0, 0, A_MONE, 1'b0};

      // Directed table: typed rows where the answer is plain, the rest predicted
      table_rows.push_back(typed_row(cam_row(0, 0, 1, 0, 0, 0), flat_z));
      table_rows.push_back(typed_row(cam_row(0, 0, 0, 0, 0, 1), back_z));
      table_rows.push_back(typed_row(cam_row(5, 7, C_MAX, 5, 7, C_MIN), flat_z));
      table_rows.push_back(typed_row(cam_row(0, 0, 0, 0, 0, 0), none));
      table_rows.push_back(typed_row(cam_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), none));
      table_rows.push_back(typed_row(cam_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), none));
      table_rows.push_back(typed_row(cam_row(0, Q_ONE, 0, 0, 0, 0), none));
      table_rows.push_back(typed_row(cam_row(0, C_MIN, 0, 0, C_MAX, 0), none));
      table_rows.push_back(cam_row(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
      table_rows.push_back(cam_row(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
      table_rows.push_back(cam_row(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
      table_rows.push_back(cam_row(1, 0, 0, 0, 0, 0));
      table_rows.push_back(cam_row(1, 1, 1, 0, 0, 0));
      table_rows.push_back(cam_row(0, 1, 1, 0, 0, 0));
      table_rows.push_back(cam_row(-1, 3, -2, 0, 0, 0));
      table_rows.push_back(cam_row(32'h00012345, 32'hfffe0001, 32'h00000007, 0, 0, 0));
      table_rows.push_back(cam_row(C_MAX, 0, 1, 0, 0, 0));
      table_rows.push_back(cam_row(0, C_MAX, 1, 0, 0, 0));
      foreach (table_rows[i]) begin
         send_cam(table_rows[i]);
         if (i % 5 == 4) idle_cycles($urandom_range(1, 3));
      end

      // Random phases, each under its own up vector
      random_phase(110);
      set_up(C_MAX, C_MIN, C_MAX);
      random_phase(110);
      set_up(0, 0, Q_ONE);
      random_phase(110);
      set_up(C_MIN, 1, 0);
      random_phase(110);
      set_up(0, 0, 0);
      random_phase(40);
      set_up(1, C_MAX, C_MIN);
      random_phase(110);
      for (int k = 0; k < 3; k++) begin
         set_up($urandom, $urandom, $urandom);
         random_phase(120);
      end

      // Wait for the last words, with a bound
      start <= 1'b0;
      limit = 0;
      while ((axes_q.size() != 0 || issue_q.size() != 0) && limit < 4 * LATENCY) begin
         @(posedge clock);
         limit++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (axes_q.size() != 0) report("words never returned", axes_q.size(), 0);

      $display("Sent %0d camera words over 9 up vectors, checked %0d, %0d degenerate.",
               words_sent, words_checked, degenerate_seen);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
